// ===== rtl/igdt_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
package igdt_pkg;

	localparam int NODE_W  = 7;
	localparam int FIELD_W = 6;

	localparam logic [1:0] ACT_CLEAR  = 2'd0;
	localparam logic [1:0] ACT_INSERT = 2'd1;
	localparam logic [1:0] ACT_QUERY  = 2'd2;

	localparam logic [6:0] DIST_CAP = 7'd127;
	localparam logic [8:0] PATH_NONE = 9'h1FF;

	typedef struct packed {
		logic [1:0]         action;
		logic [FIELD_W-1:0] node_a;
		logic [FIELD_W-1:0] node_b;
	} item_t;

	typedef struct packed {
		logic [FIELD_W-1:0] undirected_distance;
		logic [FIELD_W-1:0] directed_distance;
		logic               status;
	} result_t;

	typedef enum logic [2:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_LOAD,
		ST_ROW,
		ST_PAIR,
		ST_DRAIN,
		ST_QWAIT
	} state_t;

	typedef enum logic [2:0] {
		OP_NONE,
		OP_CLEAR,
		OP_LOAD_COL,
		OP_LOAD_ROW,
		OP_ROW,
		OP_PAIR,
		OP_QUERY
	} op_t;

	typedef struct packed {
		op_t               op;
		logic              capture;
		logic [NODE_W-1:0] i;
		logic [NODE_W-1:0] j;
	} cmd_t;

	typedef struct packed {
		logic [NODE_W-1:0] n;
		logic              in_range;
		logic              self_loop;
		logic              clr_last;
		logic              res_busy;
	} stat_t;

	// effective distance: unreach set for a stored zero off the diagonal
	typedef struct packed {
		logic       unreach;
		logic [6:0] hops;
	} eff_t;

	typedef struct packed {
		eff_t dcol;
		eff_t drow;
		eff_t ucol;
		eff_t urow;
	} scratch_t;

endpackage
`default_nettype wire

// ===== rtl/igdt_ram.sv =====
`timescale 1ns / 1ps
`default_nettype none
module igdt_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 64
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule
`default_nettype wire

// ===== rtl/igdt_ctrl.sv =====
`timescale 1ns / 1ps
`default_nettype none
module igdt_ctrl (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire logic           item_valid,
	input  wire logic [1:0]     action,
	input  wire logic           cfg_wr,
	input  wire igdt_pkg::stat_t status,
	output logic                item_stall,
	output igdt_pkg::cmd_t      cmd
);
	import igdt_pkg::*;

	state_t            state_q, state_d;
	logic [NODE_W-1:0] i_q, i_d, j_q, j_d;
	logic              ph_q, ph_d;
	logic              ready, accept;
	logic [NODE_W-1:0] last;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLEAR;
			i_q     <= '0;
			j_q     <= '0;
			ph_q    <= 1'b0;
		end else begin
			state_q <= state_d;
			i_q     <= i_d;
			j_q     <= j_d;
			ph_q    <= ph_d;
		end
	end

	always_comb begin
		state_d     = state_q;
		i_d         = i_q;
		j_d         = j_q;
		ph_d        = ph_q;
		cmd.op      = OP_NONE;
		cmd.capture = 1'b0;
		cmd.i       = i_q;
		cmd.j       = j_q;
		last        = status.n - NODE_W'(1);
		ready       = (state_q == ST_IDLE) && !status.res_busy;
		accept      = item_valid && ready;
		item_stall  = !ready;
		unique case (state_q)
			ST_CLEAR: begin
				cmd.op = OP_CLEAR;
				if (status.clr_last) begin
					state_d = ST_IDLE;
				end
			end
			ST_IDLE: begin
				if (accept) begin
					cmd.capture = 1'b1;
					unique case (action)
						ACT_CLEAR: begin
							state_d = ST_CLEAR;
						end
						ACT_INSERT: begin
							if (status.in_range && !status.self_loop) begin
								state_d = ST_LOAD;
								j_d     = '0;
								ph_d    = 1'b0;
							end
						end
						ACT_QUERY: begin
							cmd.op  = OP_QUERY;
							state_d = ST_QWAIT;
						end
						default: ;
					endcase
				end
			end
			ST_LOAD: begin
				// column read then row read for each node
				cmd.op = ph_q ? OP_LOAD_ROW : OP_LOAD_COL;
				ph_d   = !ph_q;
				if (ph_q) begin
					if (j_q == last) begin
						state_d = ST_ROW;
						i_d     = '0;
					end else begin
						j_d = j_q + NODE_W'(1);
					end
				end
			end
			ST_ROW: begin
				cmd.op  = OP_ROW;
				state_d = ST_PAIR;
				j_d     = '0;
			end
			ST_PAIR: begin
				cmd.op = OP_PAIR;
				if (j_q == last) begin
					if (i_q == last) begin
						state_d = ST_DRAIN;
					end else begin
						i_d     = i_q + NODE_W'(1);
						state_d = ST_ROW;
					end
				end else begin
					j_d = j_q + NODE_W'(1);
				end
			end
			ST_DRAIN: begin
				state_d = ST_IDLE;
			end
			ST_QWAIT: begin
				state_d = ST_IDLE;
			end
			default: begin
				state_d = ST_CLEAR;
			end
		endcase
		if (cfg_wr) begin
			state_d = ST_CLEAR;
		end
	end

endmodule
`default_nettype wire

// ===== rtl/igdt_datapath.sv =====
`timescale 1ns / 1ps
`default_nettype none
module igdt_datapath #(
	parameter int MAX_NODES = 64
) (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire igdt_pkg::item_t item,
	input  wire logic            cfg_wr,
	input  wire logic [6:0]      cfg_data,
	input  wire igdt_pkg::cmd_t  cmd,
	input  wire logic            result_stall,
	output igdt_pkg::stat_t      status,
	output igdt_pkg::result_t    result,
	output logic                 result_valid
);
	import igdt_pkg::*;

	localparam int DEPTH = MAX_NODES * MAX_NODES;
	localparam int AW    = $clog2(DEPTH);
	localparam int SW    = $clog2(MAX_NODES);
	localparam int SCR_W = $bits(scratch_t);

	function automatic logic [AW-1:0] addr_of(input logic [NODE_W-1:0] r,
		input logic [NODE_W-1:0] c);
		return AW'(int'(r) * MAX_NODES + int'(c));
	endfunction

	function automatic eff_t to_eff(input logic [6:0] v, input logic diag);
		eff_t e;
		e.unreach = !diag && (v == 7'd0);
		e.hops    = diag ? 7'd0 : v;
		return e;
	endfunction

	function automatic logic [8:0] plen(input eff_t x, input eff_t y);
		if (x.unreach || y.unreach) begin
			return PATH_NONE;
		end
		return 9'(x.hops) + 9'(y.hops) + 9'd1;
	endfunction

	function automatic logic [6:0] sat(input logic [8:0] v);
		return (v > 9'(DIST_CAP)) ? DIST_CAP : v[6:0];
	endfunction

	logic [6:0]        node_count_q;
	logic [NODE_W-1:0] n_eff;
	logic [FIELD_W-1:0] a_q, b_q;
	logic              range_q, self_q;
	logic [NODE_W-1:0] a7, b7;
	logic [AW-1:0]     clr_q;

	op_t               op_s1;
	logic [NODE_W-1:0] i_s1, j_s1;
	logic [AW-1:0]     addr_s1;

	logic [AW-1:0]     t_raddr, t_waddr;
	logic              we_u, we_d;
	logic [6:0]        wd_u, wd_d, rd_u, rd_d;

	logic [SW-1:0]     s_raddr, s_waddr;
	logic              s_we;
	scratch_t          s_wdata, s_rdata;
	logic [SCR_W-1:0]  s_rbits;

	eff_t              dcol_q, ucol_q, ci_d_q, ci_u_q, ri_u_q;
	logic [8:0]        c1, c2, cu, cd, u_old, d_old;
	logic              res_valid_q;
	result_t           result_q;

	assign n_eff = (int'(node_count_q) > MAX_NODES) ? NODE_W'(MAX_NODES) : node_count_q;
	assign a7    = {1'b0, a_q};
	assign b7    = {1'b0, b_q};

	assign status.n         = n_eff;
	assign status.in_range  = ({1'b0, item.node_a} < n_eff) && ({1'b0, item.node_b} < n_eff);
	assign status.self_loop = item.node_a == item.node_b;
	assign status.clr_last  = clr_q == AW'(DEPTH - 1);
	assign status.res_busy  = res_valid_q && result_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			node_count_q <= '0;
			clr_q        <= '0;
			op_s1        <= OP_NONE;
			res_valid_q  <= 1'b0;
		end else begin
			if (cfg_wr) begin
				node_count_q <= cfg_data;
			end
			if (cfg_wr) begin
				clr_q <= '0;
			end else if (cmd.op == OP_CLEAR) begin
				clr_q <= status.clr_last ? '0 : clr_q + AW'(1);
			end
			op_s1 <= cmd.op;
			if (op_s1 == OP_QUERY) begin
				res_valid_q <= 1'b1;
			end else if (!result_stall) begin
				res_valid_q <= 1'b0;
			end
		end
	end

	// table read address
	always_comb begin
		case (cmd.op)
			OP_LOAD_COL: t_raddr = addr_of(cmd.j, a7);
			OP_LOAD_ROW: t_raddr = addr_of(b7, cmd.j);
			OP_PAIR:     t_raddr = addr_of(cmd.i, cmd.j);
			OP_QUERY:    t_raddr = status.in_range ?
				addr_of({1'b0, item.node_a}, {1'b0, item.node_b}) : '0;
			default:     t_raddr = '0;
		endcase
	end

	assign s_raddr = (cmd.op == OP_ROW) ? SW'(cmd.i) : SW'(cmd.j);
	assign s_rdata = scratch_t'(s_rbits);

	// relaxation of one pair against the saved column and row
	assign c1    = plen(ci_u_q, s_rdata.urow);
	assign c2    = plen(ri_u_q, s_rdata.ucol);
	assign cu    = (c1 < c2) ? c1 : c2;
	assign cd    = plen(ci_d_q, s_rdata.drow);
	assign u_old = (rd_u == 7'd0) ? PATH_NONE : 9'(rd_u);
	assign d_old = (rd_d == 7'd0) ? PATH_NONE : 9'(rd_d);

	always_comb begin
		we_u    = 1'b0;
		we_d    = 1'b0;
		t_waddr = addr_s1;
		wd_u    = sat(cu);
		wd_d    = sat(cd);
		if (cmd.op == OP_CLEAR) begin
			we_u    = 1'b1;
			we_d    = 1'b1;
			t_waddr = clr_q;
			wd_u    = '0;
			wd_d    = '0;
		end else if (op_s1 == OP_PAIR && i_s1 != j_s1) begin
			we_u = cu < u_old;
			we_d = cd < d_old;
		end
	end

	assign s_we          = op_s1 == OP_LOAD_ROW;
	assign s_waddr       = SW'(j_s1);
	assign s_wdata.dcol  = dcol_q;
	assign s_wdata.ucol  = ucol_q;
	assign s_wdata.drow  = to_eff(rd_d, b7 == j_s1);
	assign s_wdata.urow  = to_eff(rd_u, b7 == j_s1);

	always_ff @(posedge clk) begin
		i_s1    <= cmd.i;
		j_s1    <= cmd.j;
		addr_s1 <= t_raddr;
		if (cmd.capture) begin
			a_q     <= item.node_a;
			b_q     <= item.node_b;
			range_q <= status.in_range;
			self_q  <= status.self_loop;
		end
		if (op_s1 == OP_LOAD_COL) begin
			dcol_q <= to_eff(rd_d, j_s1 == a7);
			ucol_q <= to_eff(rd_u, j_s1 == a7);
		end
		if (op_s1 == OP_ROW) begin
			ci_d_q <= s_rdata.dcol;
			ci_u_q <= s_rdata.ucol;
			ri_u_q <= s_rdata.urow;
		end
		if (op_s1 == OP_QUERY) begin
			result_q.undirected_distance <= (range_q && !self_q) ? rd_u[FIELD_W-1:0] : '0;
			result_q.directed_distance   <= (range_q && !self_q) ? rd_d[FIELD_W-1:0] : '0;
			result_q.status              <= !range_q;
		end
	end

	assign result       = result_q;
	assign result_valid = res_valid_q;

	igdt_ram #(.WIDTH(7), .DEPTH(DEPTH)) u_und_tbl (
		.clk   (clk),
		.we    (we_u),
		.waddr (t_waddr),
		.wdata (wd_u),
		.raddr (t_raddr),
		.rdata (rd_u)
	);

	igdt_ram #(.WIDTH(7), .DEPTH(DEPTH)) u_dir_tbl (
		.clk   (clk),
		.we    (we_d),
		.waddr (t_waddr),
		.wdata (wd_d),
		.raddr (t_raddr),
		.rdata (rd_d)
	);

	igdt_ram #(.WIDTH(SCR_W), .DEPTH(MAX_NODES)) u_scratch (
		.clk   (clk),
		.we    (s_we),
		.waddr (s_waddr),
		.wdata (SCR_W'(s_wdata)),
		.raddr (s_raddr),
		.rdata (s_rbits)
	);

endmodule
`default_nettype wire

// ===== rtl/incremental_graph_distance_table_core.sv =====
`timescale 1ns / 1ps
`default_nettype none
// hop-distance tables (undirected and directed) for a graph of up to MAX_NODES nodes
// item channel: item_valid / item_stall carry clear, insert-edge and query transactions
// result channel: result_valid / result_stall carry one result per query transaction
// cfg channel: cfg_valid / cfg_ready write node_count; every write also clears the tables
// one item is worked on at a time; the input stalls until the current item is done
// query: table read, then result register; the next item waits while the result stalls
// clear: one table write per cycle over all MAX_NODES*MAX_NODES entries
// insert: column a and row b are copied into the scratch buffer, column then row per node,
//   then the pair sweep over the first n nodes fetches row i, then does one read-modify-write
//   a cycle per pair, then a drain state; n is node_count capped at MAX_NODES
// self-loop, out-of-range insert and unused action codes are dropped and give no result
// reset: a clearing pass over all MAX_NODES*MAX_NODES entries runs with the input stalled,
//   configuration writes are still taken
// a stalled result holds in the output register; every new item waits until the result
//   transaction is taken
module incremental_graph_distance_table_core #(
	parameter int MAX_NODES = 64
) (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              item_valid,
	output logic                   item_stall,
	input  wire igdt_pkg::item_t   item,
	output logic                   result_valid,
	input  wire logic              result_stall,
	output igdt_pkg::result_t      result,
	input  wire logic              cfg_valid,
	output logic                   cfg_ready,
	input  wire logic [6:0]        cfg_data
);
	import igdt_pkg::*;

	cmd_t  cmd;
	stat_t status;
	logic  cfg_wr;

	// config register is always writable
	assign cfg_ready = 1'b1;
	assign cfg_wr    = cfg_valid && cfg_ready;

	// sequencer: clear pass, scratch load, pair sweep, query
	igdt_ctrl u_ctrl (
		.clk        (clk),
		.arst_n     (arst_n),
		.item_valid (item_valid),
		.action     (item.action),
		.cfg_wr     (cfg_wr),
		.status     (status),
		.item_stall (item_stall),
		.cmd        (cmd)
	);

	// tables, scratch buffer, relaxation and result register
	igdt_datapath #(.MAX_NODES(MAX_NODES)) u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.item         (item),
		.cfg_wr       (cfg_wr),
		.cfg_data     (cfg_data),
		.cmd          (cmd),
		.result_stall (result_stall),
		.status       (status),
		.result       (result),
		.result_valid (result_valid)
	);

endmodule
`default_nettype wire

// ===== rtl/igdt_checker.sv =====
`timescale 1ns / 1ps
`default_nettype none
module igdt_checker (
	input wire logic              clk,
	input wire logic              arst_n,
	input wire logic              item_valid,
	input wire logic              item_stall,
	input wire igdt_pkg::item_t   item,
	input wire logic              result_valid,
	input wire logic              result_stall,
	input wire igdt_pkg::result_t result,
	input wire logic              cfg_valid,
	input wire logic              cfg_ready,
	input wire logic [6:0]        cfg_data
);
	import igdt_pkg::*;

	logic acc_q, acc_other;

	assign acc_q     = item_valid && !item_stall && item.action == ACT_QUERY;
	assign acc_other = item_valid && !item_stall && item.action != ACT_QUERY;

	// a query result shows after the table read and the result register
	a_query_latency: assert property (@(posedge clk) disable iff (!arst_n)
		acc_q |-> ##2 result_valid)
		else $error("query result late");

	// only queries produce results
	a_no_spurious: assert property (@(posedge clk) disable iff (!arst_n)
		acc_other && !result_valid && !cfg_valid |-> ##2 !result_valid)
		else $error("result without query");

	// input holds off while a query is in flight
	a_query_busy: assert property (@(posedge clk) disable iff (!arst_n)
		acc_q |=> item_stall)
		else $error("item taken during query");

	a_result_hold: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && result_stall |=> result_valid && $stable(result))
		else $error("stalled result changed");

endmodule

bind incremental_graph_distance_table_core igdt_checker u_igdt_checker (.*);
`default_nettype wire

// ===== test/tb_incremental_graph_distance_table_core.sv =====
`timescale 1ns / 1ps
module tb_incremental_graph_distance_table_core;
	import igdt_pkg::*;

	localparam int NODES = 64;
	localparam logic [1:0] ACT_UNUSED = 2'd3;
	// longest silent work: a clear sweep or an insert at 64 nodes
	localparam int SETTLE = 4600;
	localparam int UNREACH = 1 << 20;

	typedef struct {
		bit          is_cfg;
		logic [6:0]  cfg_value;
		item_t       it;
		bit          typed;
		result_t     res;
	} step_t;

	logic        clk;
	logic        arst_n;
	logic        item_valid;
	logic        item_stall;
	item_t       item;
	logic        result_valid;
	logic        result_stall;
	result_t     result;
	logic        cfg_valid;
	logic        cfg_ready;
	logic [6:0]  cfg_data;

	// predictor state
	logic [6:0]  und_dist [NODES*NODES];
	logic [6:0]  dir_dist [NODES*NODES];
	logic [6:0]  nodes_in_use;

	result_t     pending_results [$];
	step_t       plan [$];
	int          mismatches;
	int          stall_left;
	bit          stall_mode;

	incremental_graph_distance_table_core u_top (
		.clk          (clk),
		.arst_n       (arst_n),
		.item_valid   (item_valid),
		.item_stall   (item_stall),
		.item         (item),
		.result_valid (result_valid),
		.result_stall (result_stall),
		.result       (result),
		.cfg_valid    (cfg_valid),
		.cfg_ready    (cfg_ready),
		.cfg_data     (cfg_data)
	);

	always begin
		clk = 1'b1;
		#5;
		clk = 1'b0;
		#5;
	end

	function automatic int active_count();
		return (nodes_in_use > NODES) ? NODES : int'(nodes_in_use);
	endfunction

	function automatic void wipe_tables();
		for (int k = 0; k < NODES*NODES; k++) begin
			und_dist[k] = '0;
			dir_dist[k] = '0;
		end
	endfunction

	function automatic int hop(bit directed, int r, int c);
		logic [6:0] v;
		if (r == c)
			return 0;
		v = directed ? dir_dist[r*NODES+c] : und_dist[r*NODES+c];
		return (v == 0) ? UNREACH : int'(v);
	endfunction

	function automatic int chain(int x, int y);
		if (x == UNREACH || y == UNREACH)
			return UNREACH;
		return x + 1 + y;
	endfunction

	function automatic void add_edge(int a, int b);
		int n;
		int dcol [NODES];
		int drow [NODES];
		int ucol [NODES];
		int urow [NODES];
		int cu;
		int cd;
		n = active_count();
		for (int i = 0; i < n; i++) begin
			dcol[i] = hop(1, i, a);
			drow[i] = hop(1, b, i);
			ucol[i] = hop(0, i, a);
			urow[i] = hop(0, b, i);
		end
		for (int i = 0; i < n; i++)
			for (int j = 0; j < n; j++) begin
				if (i == j)
					continue;
				cu = chain(ucol[i], urow[j]);
				if (chain(urow[i], ucol[j]) < cu)
					cu = chain(urow[i], ucol[j]);
				if (cu < hop(0, i, j))
					und_dist[i*NODES+j] = (cu > 127) ? DIST_CAP : 7'(cu);
				cd = chain(dcol[i], drow[j]);
				if (cd < hop(1, i, j))
					dir_dist[i*NODES+j] = (cd > 127) ? DIST_CAP : 7'(cd);
			end
	endfunction

	// returns 1 when the item yields a result
	function automatic bit apply_item(item_t x, output result_t r);
		int n;
		bit ok;
		n = active_count();
		ok = (int'(x.node_a) < n) && (int'(x.node_b) < n);
		r = '0;
		case (x.action)
			ACT_CLEAR: begin
				wipe_tables();
				return 0;
			end
			ACT_INSERT: begin
				if (ok && x.node_a != x.node_b)
					add_edge(x.node_a, x.node_b);
				return 0;
			end
			ACT_QUERY: begin
				if (!ok)
					r.status = 1'b1;
				else if (x.node_a != x.node_b) begin
					r.undirected_distance = und_dist[x.node_a*NODES+x.node_b][5:0];
					r.directed_distance   = dir_dist[x.node_a*NODES+x.node_b][5:0];
				end
				return 1;
			end
			default: return 0;
		endcase
	endfunction

	function automatic step_t cfg_row(logic [6:0] v);
		step_t s;
		s = '{default: '0};
		s.is_cfg = 1;
		s.cfg_value = v;
		return s;
	endfunction

	function automatic step_t item_row(logic [1:0] act, int a, int b);
		step_t s;
		s = '{default: '0};
		s.it = '{action: act, node_a: 6'(a), node_b: 6'(b)};
		return s;
	endfunction

	function automatic step_t known_row(int a, int b, int ud, int dd, bit st);
		step_t s;
		s = item_row(ACT_QUERY, a, b);
		s.typed = 1;
		s.res = '{undirected_distance: 6'(ud), directed_distance: 6'(dd), status: st};
		return s;
	endfunction

	function automatic int pick_gap();
		int roll;
		roll = $urandom_range(0, 99);
		if (roll < 50)
			return 0;
		if (roll < 92)
			return $urandom_range(1, 3);
		return $urandom_range(10, 60);
	endfunction

	task automatic send_item(step_t s);
		result_t r;
		int gap;
		item <= s.it;
		if (!item_valid)
			item_valid <= 1'b1;
		do @(posedge clk); while (item_stall);
		if (apply_item(s.it, r))
			pending_results.push_back(s.typed ? s.res : r);
		gap = pick_gap();
		if (gap > 0) begin
			item_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
	endtask

	task automatic drain_and_idle();
		if (item_valid)
			item_valid <= 1'b0;
		@(posedge clk);
		while (pending_results.size() != 0)
			@(posedge clk);
		// an insert or a clear may still be sweeping
		repeat (SETTLE) @(posedge clk);
	endtask

	task automatic write_node_count(logic [6:0] v);
		drain_and_idle();
		cfg_data <= v;
		cfg_valid <= 1'b1;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		nodes_in_use = v;
		wipe_tables();
	endtask

	function automatic step_t random_row(int n);
		int roll;
		int ins_pct;
		int a;
		int b;
		logic [1:0] act;
		// keep insert sweeps rare when the graph is large
		ins_pct = (n > 32) ? 10 : 45;
		roll = $urandom_range(0, 99);
		if (roll < ins_pct)
			act = ACT_INSERT;
		else if (roll < 92)
			act = ACT_QUERY;
		else if (roll < 96)
			act = ACT_CLEAR;
		else
			act = ACT_UNUSED;
		if (n > 0 && $urandom_range(0, 99) < 85) begin
			a = $urandom_range(0, n - 1);
			b = $urandom_range(0, n - 1);
		end else begin
			a = $urandom_range(0, 63);
			b = $urandom_range(0, 63);
		end
		return item_row(act, a, b);
	endfunction

	// result side stall pattern: short bursts mostly, a few long ones
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_stall <= 1'b0;
			stall_left <= 0;
			stall_mode <= 1'b0;
		end else if (stall_left == 0) begin
			stall_mode <= ~stall_mode;
			result_stall <= ~stall_mode;
			if (stall_mode)
				stall_left <= $urandom_range(1, 30);
			else if ($urandom_range(0, 9) == 0)
				stall_left <= $urandom_range(15, 50);
			else
				stall_left <= $urandom_range(1, 3);
		end else begin
			stall_left <= stall_left - 1;
		end
	end

	// compare every accepted result transaction with the oldest prediction
	always @(posedge clk) begin
		result_t want;
		if (arst_n && result_valid && !result_stall) begin
			if (pending_results.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("unexpected result %h", result);
			end else begin
				want = pending_results.pop_front();
				if (result.undirected_distance !== want.undirected_distance ||
						result.directed_distance !== want.directed_distance ||
						result.status !== want.status) begin
					mismatches++;
					if (mismatches <= 10)
						$display("result mismatch: und %0d/%0d dir %0d/%0d st %0d/%0d",
							want.undirected_distance, result.undirected_distance,
							want.directed_distance, result.directed_distance,
							want.status, result.status);
				end
			end
		end
	end

	initial begin
		#50ms;
		$display("tb: failure");
		$finish;
	end

	initial begin
		logic [6:0] phase_cfg [7];
		int n;
		arst_n = 1'b0;
		item_valid = 1'b0;
		item = '0;
		cfg_valid = 1'b0;
		cfg_data = '0;
		mismatches = 0;
		nodes_in_use = '0;
		wipe_tables();
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;

		// no nodes in use after reset
		plan.push_back(known_row(0, 0, 0, 0, 1));
		plan.push_back(known_row(63, 63, 0, 0, 1));
		plan.push_back(item_row(ACT_INSERT, 0, 1));
		plan.push_back(item_row(ACT_UNUSED, 63, 63));
		// full size graph, corner nodes
		plan.push_back(cfg_row(7'd64));
		plan.push_back(known_row(0, 63, 0, 0, 0));
		plan.push_back(item_row(ACT_INSERT, 0, 63));
		plan.push_back(known_row(0, 63, 1, 1, 0));
		plan.push_back(known_row(63, 0, 1, 0, 0));
		plan.push_back(item_row(ACT_INSERT, 63, 62));
		plan.push_back(item_row(ACT_QUERY, 0, 62));
		plan.push_back(item_row(ACT_QUERY, 62, 0));
		plan.push_back(item_row(ACT_INSERT, 5, 5));
		plan.push_back(known_row(5, 5, 0, 0, 0));
		plan.push_back(item_row(ACT_UNUSED, 42, 21));
		plan.push_back(item_row(ACT_CLEAR, 63, 0));
		plan.push_back(known_row(0, 63, 0, 0, 0));
		// oversized count behaves as the full size
		plan.push_back(cfg_row(7'd100));
		plan.push_back(item_row(ACT_INSERT, 63, 0));
		plan.push_back(known_row(63, 0, 1, 1, 0));
		// smallest useful graph, out of range operands
		plan.push_back(cfg_row(7'd2));
		plan.push_back(known_row(2, 0, 0, 0, 1));
		plan.push_back(item_row(ACT_INSERT, 0, 2));
		plan.push_back(item_row(ACT_INSERT, 1, 0));
		plan.push_back(known_row(0, 1, 1, 0, 0));
		plan.push_back(known_row(1, 0, 1, 1, 0));

		foreach (plan[k]) begin
			if (plan[k].is_cfg)
				write_node_count(plan[k].cfg_value);
			else
				send_item(plan[k]);
		end

		phase_cfg = '{7'd5, 7'd16, 7'd127, 7'd0, 7'd9, 7'd64, 7'd3};
		foreach (phase_cfg[p]) begin
			write_node_count(phase_cfg[p]);
			n = active_count();
			repeat (20)
				send_item(random_row(n));
		end

		if (item_valid)
			item_valid <= 1'b0;
		while (pending_results.size() != 0)
			@(posedge clk);
		repeat (SETTLE) @(posedge clk);
		if (mismatches == 0 && pending_results.size() == 0) begin
			$display("tb: success");
		end else begin
			$display("tb: failure");
		end
		$finish;
	end

endmodule
